// ===== hdl/bstp_pkg.sv =====
// ----------------------------------------------------------------------------
// bstp_pkg
// Types and constants shared by the byte size text parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bstp_pkg;

    localparam int unsigned CHAR_W  = 16;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned STEP_W  = 11;
    localparam int unsigned EXP_W   = 3;
    localparam int unsigned MUL_STAGES = 4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    localparam logic [CHAR_W-1:0] CH_B = 16'h0042;
    localparam logic [CHAR_W-1:0] CH_K = 16'h004B;
    localparam logic [CHAR_W-1:0] CH_M = 16'h004D;
    localparam logic [CHAR_W-1:0] CH_G = 16'h0047;
    localparam logic [CHAR_W-1:0] CH_T = 16'h0054;

    localparam logic [STEP_W-1:0] STEP_BIN = 11'd1024;
    localparam logic [STEP_W-1:0] STEP_DEC = 11'd1000;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_NUMBER,
        PH_UNIT
    } t_phase;

    typedef struct packed {
        logic [1:0]         status;
        logic [VALUE_W-1:0] value;
        logic [EXP_W-1:0]   mul_count;
        logic               decimal;
    } t_stage;

endpackage

`default_nettype wire

// ===== hdl/bstp_mul_stage.sv =====
// ----------------------------------------------------------------------------
// bstp_mul_stage
// One pipeline stage of the unit scaling: multiplies by 1024 or 1000 while
// multiplies remain, flags overflow as out of range.
// ----------------------------------------------------------------------------
`default_nettype none

module bstp_mul_stage
    import bstp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_up_valid,
    input  wire t_stage i_up_item,
    output logic        o_up_ready,
    input  wire logic   i_dn_ready,
    output logic        o_dn_valid,
    output t_stage      o_dn_item
);

    localparam int unsigned PROD_W = VALUE_W + STEP_W;

    logic              r_valid;
    t_stage            r_item;
    t_stage            n_item;
    logic [STEP_W-1:0] step;
    logic [PROD_W-1:0] prod;

    assign step = i_up_item.decimal ? STEP_DEC : STEP_BIN;
    assign prod = PROD_W'(i_up_item.value) * PROD_W'(step);

    always_comb begin
        n_item = i_up_item;
        if (i_up_item.status == ST_OK && i_up_item.mul_count != '0) begin
            n_item.mul_count = i_up_item.mul_count - EXP_W'(1);
            if (|prod[PROD_W-1:VALUE_W]) begin
                n_item.status = ST_RANGE;
                n_item.value  = '0;
            end else begin
                n_item.value = prod[VALUE_W-1:0];
            end
        end
    end

    assign o_up_ready = !r_valid || i_dn_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_valid <= i_up_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_up_ready) begin
            r_item <= n_item;
        end
    end

    assign o_dn_valid = r_valid;
    assign o_dn_item  = r_item;

endmodule

`default_nettype wire

// ===== hdl/byte_size_text_parser_top.sv =====
// ----------------------------------------------------------------------------
// byte_size_text_parser_top
// Parses a human readable size string, one character per word, into a byte
// count with ok / invalid / out of range status.
// ----------------------------------------------------------------------------
// Takes one character word every cycle while o_in_stall is low, with no gaps
// needed between strings. The result of a string is registered after the word
// marked last is accepted: the accepting edge registers the character parse and
// unit decode, then four pipelined multiply stages follow (one per unit power,
// 1024 or 1000), the last of which is the output register. Results can leave at
// one per cycle, so even strings of one character each run at full rate; a
// stalled output fills the pipeline before the input stalls. decimal_base is
// written through the configuration channel, which is always ready, and must
// only change while no string is in flight.
`default_nettype none

module byte_size_text_parser_top
    import bstp_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [CHAR_W-1:0]   i_char_code,
    input  wire logic                i_char_present,
    input  wire logic                i_last_char,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [1:0]               o_status,
    output logic [VALUE_W-1:0]       o_byte_count,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic                i_decimal_base
);

    logic r_decimal_base;

    t_phase             r_phase,   n_phase;
    logic [VALUE_W-1:0] r_value,   n_value;
    logic               r_seen,    n_seen;
    logic               r_ovf,     n_ovf;
    logic [1:0]         r_ulen,    n_ulen;
    logic [1:0]         r_pend,    n_pend;
    logic [CHAR_W-1:0]  r_first,   n_first;
    logic [CHAR_W-1:0]  r_second,  n_second;

    logic               accept;
    logic               is_ws;
    logic               is_digit;
    logic               take_unit;
    logic [VALUE_W+3:0] digit_prod;
    logic [2:0]         unit_pos;

    logic               r_s0_valid;
    t_stage             r_s0;
    t_stage             fin;
    logic               s0_ready;

    logic               stg_valid [MUL_STAGES+1];
    t_stage             stg_item  [MUL_STAGES+1];
    logic               stg_ready [MUL_STAGES+1];

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decimal_base <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_decimal_base <= i_decimal_base;
        end
    end

    // character parse
    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = !s0_ready;

    assign is_ws    = (i_char_code >= 16'd9 && i_char_code <= 16'd13) ||
                      i_char_code == 16'd32;
    assign is_digit = i_char_code >= 16'd48 && i_char_code <= 16'd57;

    assign digit_prod = ({4'b0, r_value} << 3) + ({4'b0, r_value} << 1) +
                        {{VALUE_W{1'b0}}, i_char_code[3:0]};
    assign unit_pos   = {1'b0, r_ulen} + {1'b0, r_pend};

    always_comb begin
        n_phase   = r_phase;
        n_value   = r_value;
        n_seen    = r_seen;
        n_ovf     = r_ovf;
        n_ulen    = r_ulen;
        n_pend    = r_pend;
        n_first   = r_first;
        n_second  = r_second;
        take_unit = 1'b0;
        if (accept && i_char_present) begin
            case (r_phase)
                PH_LEAD: begin
                    if (is_digit) begin
                        n_phase = PH_NUMBER;
                    end else if (!is_ws) begin
                        n_phase   = PH_UNIT;
                        take_unit = 1'b1;
                    end
                end
                PH_NUMBER: begin
                    if (!is_digit) begin
                        n_phase   = PH_UNIT;
                        take_unit = 1'b1;
                    end
                end
                PH_UNIT: begin
                    take_unit = 1'b1;
                end
                default: begin
                    n_phase = PH_LEAD;
                end
            endcase
            if (is_digit && (r_phase == PH_LEAD || r_phase == PH_NUMBER)) begin
                n_seen = 1'b1;
                if (!r_ovf) begin
                    if (|digit_prod[VALUE_W+3:VALUE_W]) begin
                        n_ovf   = 1'b1;
                        n_value = '0;
                    end else begin
                        n_value = digit_prod[VALUE_W-1:0];
                    end
                end
            end
            if (take_unit) begin
                if (is_ws) begin
                    if (r_ulen != 2'd0 && r_pend != 2'd3) begin
                        n_pend = r_pend + 2'd1;
                    end
                end else begin
                    if (unit_pos == 3'd0) begin
                        n_first = i_char_code;
                    end
                    if (unit_pos == 3'd1) begin
                        n_second = i_char_code;
                    end
                    n_ulen = (unit_pos >= 3'd2) ? 2'd3 : 2'(unit_pos + 3'd1);
                    n_pend = 2'd0;
                end
            end
        end
    end

    // end of string decode
    always_comb begin
        fin.status    = ST_OK;
        fin.value     = '0;
        fin.mul_count = '0;
        fin.decimal   = r_decimal_base;
        if (!n_seen) begin
            fin.status = ST_INVALID;
        end else if (n_ovf) begin
            fin.status = ST_RANGE;
        end else if (n_ulen == 2'd3 || (n_ulen == 2'd2 && n_second != CH_B)) begin
            fin.status = ST_INVALID;
        end else begin
            fin.value = n_value;
            if (n_ulen != 2'd0 && n_first != CH_B) begin
                case (n_first)
                    CH_K:    fin.mul_count = EXP_W'(1);
                    CH_M:    fin.mul_count = EXP_W'(2);
                    CH_G:    fin.mul_count = EXP_W'(3);
                    CH_T:    fin.mul_count = EXP_W'(4);
                    default: begin
                        fin.status = ST_INVALID;
                        fin.value  = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_last_char)) begin
            r_phase  <= PH_LEAD;
            r_value  <= '0;
            r_seen   <= 1'b0;
            r_ovf    <= 1'b0;
            r_ulen   <= 2'd0;
            r_pend   <= 2'd0;
            r_first  <= '0;
            r_second <= '0;
        end else begin
            r_phase  <= n_phase;
            r_value  <= n_value;
            r_seen   <= n_seen;
            r_ovf    <= n_ovf;
            r_ulen   <= n_ulen;
            r_pend   <= n_pend;
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

    // decoded result register
    assign s0_ready = !r_s0_valid || stg_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (s0_ready) begin
            r_s0_valid <= accept && i_last_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_ready) begin
            r_s0 <= fin;
        end
    end

    // unit scaling pipeline
    assign stg_valid[0] = r_s0_valid;
    assign stg_item[0]  = r_s0;
    assign stg_ready[MUL_STAGES] = !i_out_stall;

    for (genvar g = 0; g < MUL_STAGES; g++) begin : g_mul
        bstp_mul_stage u_stage (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_up_valid (stg_valid[g]),
            .i_up_item  (stg_item[g]),
            .o_up_ready (stg_ready[g]),
            .i_dn_ready (stg_ready[g+1]),
            .o_dn_valid (stg_valid[g+1]),
            .o_dn_item  (stg_item[g+1])
        );
    end

    assign o_out_valid  = stg_valid[MUL_STAGES];
    assign o_status     = stg_item[MUL_STAGES].status;
    assign o_byte_count = stg_item[MUL_STAGES].value;

endmodule

`default_nettype wire

// ===== hdl/bstp_checker.sv =====
// ----------------------------------------------------------------------------
// bstp_checker
// Port level checks on the byte size text parser result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bstp_checker
    import bstp_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic [1:0]         o_status,
    input wire logic [VALUE_W-1:0] o_byte_count
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word present right after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result word dropped");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_INVALID ||
                         o_status == ST_RANGE))
        else $error("undefined status code");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> o_byte_count == '0)
        else $error("nonzero byte count on error");

endmodule

bind byte_size_text_parser_top bstp_checker u_bstp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_status     (o_status),
    .o_byte_count (o_byte_count)
);

`default_nettype wire

// ===== dv/byte_size_text_parser_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_size_text_parser_top_tb
// Self-checking bench for the byte size text parser. Size strings are built
// from well-formed pieces (leading spaces, digits, units, trailing spaces)
// mixed with absent and random noise words. They are sent one character word
// at a time under random idling and output stall. A behavioral parser
// predicts the status and byte count of every string, and each result is
// checked in order. The run covers both multiplier bases.
// ----------------------------------------------------------------------------

module byte_size_text_parser_top_tb;

    import bstp_pkg::*;

    localparam logic [VALUE_W-1:0] U64_MAX = '1;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              present;
        logic              is_last;
    } t_char_word;

    typedef struct packed {
        logic [1:0]         status;
        logic [VALUE_W-1:0] count;
    } t_size_result;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic [CHAR_W-1:0]   i_char_code    = '0;
    logic                i_char_present = 1'b0;
    logic                i_last_char    = 1'b0;
    logic                i_out_stall    = 1'b0;
    logic                i_cfg_valid    = 1'b0;
    logic                i_decimal_base = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [1:0]          o_status;
    logic [VALUE_W-1:0]  o_byte_count;
    logic                o_cfg_ready;

    byte_size_text_parser_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_char_code    (i_char_code),
        .i_char_present (i_char_present),
        .i_last_char    (i_last_char),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_byte_count   (o_byte_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_decimal_base (i_decimal_base)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_char_word         pending_words[$];
    t_size_result       size_results_q[$];
    logic [CHAR_W-1:0]  text_buf[$];

    int   words_queued = 0;
    int   words_sent   = 0;
    int   cfg_writes   = 0;
    int   errors       = 0;
    int   in_gap       = 0;
    int   out_wait     = 0;
    bit   quiet        = 1'b0;
    logic in_taken     = 1'b0;
    logic out_taken    = 1'b0;

    // parser state
    logic               cfg_decimal = 1'b0;
    t_phase             ph;
    logic [VALUE_W-1:0] num_val;
    logic               dig_seen;
    logic               num_ovf;
    logic [1:0]         unit_len;
    logic [1:0]         pend_sp;
    logic [CHAR_W-1:0]  unit_c0;
    logic [CHAR_W-1:0]  unit_c1;

    function automatic logic is_space(logic [CHAR_W-1:0] c);
        return (c >= 16'd9 && c <= 16'd13) || c == 16'd32;
    endfunction

    function automatic logic is_dec_digit(logic [CHAR_W-1:0] c);
        return c >= 16'd48 && c <= 16'd57;
    endfunction

    function automatic logic [VALUE_W-1:0] unit_scale(logic [CHAR_W-1:0] letter, logic dec);
        logic [VALUE_W-1:0] step;
        logic [VALUE_W-1:0] m;
        int                 n;
        step = dec ? VALUE_W'(STEP_DEC) : VALUE_W'(STEP_BIN);
        m = 1;
        case (letter)
            CH_K: n = 1;
            CH_M: n = 2;
            CH_G: n = 3;
            CH_T: n = 4;
            default: n = 0;
        endcase
        if (n == 0) return '0;
        repeat (n) m = m * step;
        return m;
    endfunction

    function automatic int idle_draw();
        return quiet ? 0 : int'($urandom_range(0, 16));
    endfunction

    task automatic clear_parse();
        ph       = PH_LEAD;
        num_val  = '0;
        dig_seen = 1'b0;
        num_ovf  = 1'b0;
        unit_len = '0;
        pend_sp  = '0;
        unit_c0  = '0;
        unit_c1  = '0;
    endtask

    task automatic parse_size_char(input logic [CHAR_W-1:0] c, input logic present,
                                   input logic is_last);
        logic [VALUE_W-1:0] d;
        logic [VALUE_W-1:0] mult;
        int                 pos;
        t_size_result       r;
        if (present) begin
            if (ph == PH_LEAD && !is_space(c)) ph = PH_NUMBER;
            if (ph == PH_NUMBER) begin
                if (is_dec_digit(c)) begin
                    d = VALUE_W'(c - 16'd48);
                    dig_seen = 1'b1;
                    if (!num_ovf) begin
                        if (num_val > (U64_MAX - d) / 64'd10) begin
                            num_ovf = 1'b1;
                            num_val = '0;
                        end else begin
                            num_val = num_val * 64'd10 + d;
                        end
                    end
                end else begin
                    ph = PH_UNIT;
                end
            end
            if (ph == PH_UNIT) begin
                if (is_space(c)) begin
                    if (unit_len != 0 && pend_sp < 2'd3) pend_sp = pend_sp + 2'd1;
                end else begin
                    pos = int'(unit_len) + int'(pend_sp);
                    if (pos == 0) unit_c0 = c;
                    else if (pos == 1) unit_c1 = c;
                    unit_len = (pos + 1 > 3) ? 2'd3 : 2'(pos + 1);
                    pend_sp = '0;
                end
            end
        end
        if (is_last) begin
            r.status = ST_OK;
            r.count  = '0;
            mult     = 64'd1;
            if (!dig_seen) begin
                r.status = ST_INVALID;
            end else if (num_ovf) begin
                r.status = ST_RANGE;
            end else if (unit_len > 2'd2 || (unit_len == 2'd2 && unit_c1 != CH_B)) begin
                r.status = ST_INVALID;
            end else begin
                if (unit_len != 0 && unit_c0 != CH_B) mult = unit_scale(unit_c0, cfg_decimal);
                if (mult == 0) r.status = ST_INVALID;
                else if (num_val > U64_MAX / mult) r.status = ST_RANGE;
                else r.count = num_val * mult;
            end
            size_results_q.push_back(r);
            clear_parse();
        end
    endtask

    // driver: one character word per handshake
    always @(negedge i_clk) begin : driver
        t_char_word w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (in_gap > 0) begin
                in_gap = in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                w = pending_words.pop_front();
                i_char_code    <= w.code;
                i_char_present <= w.present;
                i_last_char    <= w.is_last;
                i_in_valid     <= 1'b1;
                in_gap = idle_draw();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : out_staller
        if (out_taken) begin
            out_wait = idle_draw();
        end else if (out_wait == 0 && !quiet && $urandom_range(0, 15) == 0) begin
            out_wait = $urandom_range(1, 16);
        end
        if (out_wait > 0) begin
            out_wait = out_wait - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_size_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (size_results_q.size() == 0) begin
                    $error("unexpected result: status %0d, byte_count %0d", o_status,
                           o_byte_count);
                    errors = errors + 1;
                end else begin
                    want = size_results_q.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        errors = errors + 1;
                    end
                    if (o_byte_count !== want.count) begin
                        $error("byte_count: expected %0d, actual %0d", want.count,
                               o_byte_count);
                        errors = errors + 1;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                parse_size_char(i_char_code, i_char_present, i_last_char);
                words_sent <= words_sent + 1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_decimal <= i_decimal_base;
                cfg_writes  <= cfg_writes + 1;
            end
        end
        in_taken  <= i_rst_n && i_in_valid && !o_in_stall;
        out_taken <= i_rst_n && o_out_valid && !i_out_stall;
    end

    task automatic add_word(input logic [CHAR_W-1:0] code, input logic present,
                            input logic is_last);
        t_char_word w;
        w.code    = code;
        w.present = present;
        w.is_last = is_last;
        pending_words.push_back(w);
        words_queued = words_queued + 1;
    endtask

    task automatic buf_str(input string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(CHAR_W'(s[i]));
    endtask

    function automatic logic [CHAR_W-1:0] space_code();
        return ($urandom_range(0, 5) == 5) ? 16'd32 : CHAR_W'($urandom_range(9, 13));
    endfunction

    // sends the buffered string, optionally with absent words mixed in
    task automatic send_buf(input bit noisy, input bit absent_end);
        int n;
        n = text_buf.size();
        for (int i = 0; i < n; i++) begin
            if (noisy && $urandom_range(0, 9) == 0)
                add_word(CHAR_W'($urandom_range(0, 65535)), 1'b0, 1'b0);
            add_word(text_buf[i], 1'b1, !absent_end && i == n - 1);
        end
        if (absent_end || n == 0) add_word(CHAR_W'($urandom_range(0, 65535)), 1'b0, 1'b1);
        text_buf.delete();
    endtask

    task automatic gen_size_text(input logic dec);
        int                 unit_sel;
        int                 kind;
        logic [CHAR_W-1:0]  letter;
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] mult;
        unit_sel = $urandom_range(0, 13);
        case ($urandom_range(0, 3))
            0: letter = CH_K;
            1: letter = CH_M;
            2: letter = CH_G;
            default: letter = CH_T;
        endcase
        mult = (unit_sel >= 3 && unit_sel <= 10) ? unit_scale(letter, dec) : 64'd1;
        if ($urandom_range(0, 1) == 1)
            repeat ($urandom_range(1, 3)) text_buf.push_back(space_code());
        kind = $urandom_range(0, 19);
        case (kind)
            0: ;
            10, 11: begin
                v = {$urandom, $urandom} >> $urandom_range(0, 63);
                buf_str($sformatf("%0d", v));
            end
            12, 13: begin
                v = U64_MAX / mult + VALUE_W'($urandom_range(0, 1));
                buf_str($sformatf("%0d", v));
            end
            14: buf_str("18446744073709551615");
            15: begin
                buf_str("1844674407370955161");
                text_buf.push_back(16'd48 + CHAR_W'($urandom_range(5, 9)));
            end
            16: begin
                text_buf.push_back(16'd48 + CHAR_W'($urandom_range(1, 9)));
                repeat ($urandom_range(19, 23))
                    text_buf.push_back(16'd48 + CHAR_W'($urandom_range(0, 9)));
            end
            17: begin
                repeat ($urandom_range(1, 5)) text_buf.push_back(16'd48);
                buf_str($sformatf("%0d", $urandom_range(0, 999)));
            end
            18, 19: buf_str($sformatf("%0d", $urandom_range(0, 9)));
            default: buf_str($sformatf("%0d", $urandom_range(0, 99999)));
        endcase
        if (unit_sel != 0 && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) text_buf.push_back(space_code());
        case (unit_sel)
            0: ;
            1: text_buf.push_back(CH_B);
            2: begin
                text_buf.push_back(CH_B);
                text_buf.push_back(CH_B);
            end
            3, 4, 5, 6: text_buf.push_back(letter);
            7, 8, 9, 10: begin
                text_buf.push_back(letter);
                text_buf.push_back(CH_B);
            end
            11: text_buf.push_back(CHAR_W'($urandom_range(33, 126)));
            12: text_buf.push_back({8'($urandom_range(1, 255)), letter[7:0]});
            default: begin
                text_buf.push_back(letter);
                text_buf.push_back(($urandom_range(0, 1) == 1) ? space_code() : CH_B);
                text_buf.push_back(CH_B);
            end
        endcase
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) text_buf.push_back(space_code());
    endtask

    task automatic gen_directed();
        add_word(16'hFFFF, 1'b0, 1'b1);
        buf_str("0");     send_buf(1'b0, 1'b0);
        buf_str(" 9TB");  send_buf(1'b0, 1'b0);
        buf_str("1BB");   send_buf(1'b0, 1'b0);
        buf_str("1K");    send_buf(1'b0, 1'b0);
        buf_str("5K B");  send_buf(1'b0, 1'b0);
        buf_str("KB");    send_buf(1'b0, 1'b0);
        buf_str("2m");    send_buf(1'b0, 1'b0);
        buf_str("3\tG\v"); send_buf(1'b0, 1'b0);
        buf_str("4");
        text_buf.push_back(16'h0142);
        send_buf(1'b0, 1'b0);
        buf_str("6M");    send_buf(1'b0, 1'b1);
        text_buf.push_back(16'h00A0);
        buf_str("7");
        send_buf(1'b0, 1'b0);
        buf_str("8B");    send_buf(1'b0, 1'b0);
    endtask

    task automatic drain_and_settle();
        while (words_sent != words_queued || size_results_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_base(input logic dec);
        int target;
        target = cfg_writes + 1;
        @(negedge i_clk);
        i_cfg_valid    <= 1'b1;
        i_decimal_base <= dec;
        do @(negedge i_clk); while (cfg_writes < target);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic dec;
        int   start;
        int   r;
        clear_parse();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < 2; p++) begin
            dec = p[0];
            write_base(dec);
            @(posedge i_clk);
            quiet = 1'b0;
            gen_directed();
            drain_and_settle();
        end

        for (int p = 0; p < 8; p++) begin
            dec = (p < 2) ? p[0] : 1'($urandom_range(0, 1));
            write_base(dec);
            @(posedge i_clk);
            quiet = (p % 3 == 2);
            start = words_queued;
            while (words_queued - start < 125) begin
                r = $urandom_range(0, 19);
                if (r == 0) begin
                    repeat ($urandom_range(1, 6))
                        text_buf.push_back(($urandom_range(0, 1) == 1) ?
                                           CHAR_W'($urandom_range(0, 65535)) :
                                           CHAR_W'($urandom_range(0, 127)));
                    send_buf(1'b1, $urandom_range(0, 3) == 0);
                end else if (r == 1) begin
                    send_buf(1'b0, 1'b1);
                end else begin
                    gen_size_text(dec);
                    send_buf($urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
                end
            end
            drain_and_settle();
        end

        if (errors == 0) begin
            $display("PASS byte_size_text_parser_top");
        end else begin
            $display("FAIL byte_size_text_parser_top");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("FAIL byte_size_text_parser_top");
        $finish;
    end

endmodule
